// ----- rtl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers; they are empty when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// Check that an expression holds at every clock edge out of reset.
`define NQ_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// Check that a consequent holds in the cycle of its antecedent.
`define NQ_ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

`else

`define NQ_ASSERT(lbl, clk, rstn, prop, msg)
`define NQ_ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg)

`endif

`endif

// ----- rtl/nqbs_pkg.sv -----
// ----------------------------------------------------------------------------
// N-queens search package
// Shared constants and helpers for the backtracking search core.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package nqbs_pkg;

    // Columns that fit the packed placement field
    localparam int PLACE_COLS  = 8;
    localparam int PLACE_BITS  = 3;
    localparam int PLACE_W     = PLACE_COLS * PLACE_BITS;

    localparam int DEF_MAX_N   = 8;

    localparam int CFG_W       = 4;
    localparam logic [CFG_W-1:0] BSIZE_RESET = 4'd8;

    localparam int SEEN_W      = 16;
    localparam logic [SEEN_W-1:0] SEEN_MAX = 16'hFFFF;

    localparam int IN_TDATA_W  = 8;
    localparam int OUT_TDATA_W = SEEN_W + PLACE_W;

    // Columns actually stored: the smaller of MAX_N and the placement width
    function automatic int nq_cols(input int max_n);
        nq_cols = (max_n < PLACE_COLS) ? max_n : PLACE_COLS;
    endfunction

endpackage

// ----- rtl/nqbs_check.sv -----
// ----------------------------------------------------------------------------
// N-queens attack check
// Compares the candidate row against one earlier queen: same row or diagonal.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module nqbs_check #(
    parameter int MAX_N = nqbs_pkg::DEF_MAX_N
) (
    input  logic [$clog2(nqbs_pkg::nq_cols(MAX_N)+1)-1:0] i_row_cur,
    input  logic [$clog2(nqbs_pkg::nq_cols(MAX_N)+1)-1:0] i_row_prev,
    input  logic [$clog2(nqbs_pkg::nq_cols(MAX_N)+1)-1:0] i_dist,
    output logic                                           o_hit
);
    import nqbs_pkg::*;

    localparam int NCOL = nq_cols(MAX_N);
    localparam int CW   = $clog2(NCOL + 1);

    logic [CW-1:0] diff;

    assign diff  = (i_row_cur >= i_row_prev) ? (i_row_cur - i_row_prev)
                                             : (i_row_prev - i_row_cur);
    assign o_hit = (i_row_cur == i_row_prev) || (diff == i_dist);

endmodule

// ----- rtl/n_queens_backtrack_search_core.sv -----
// ----------------------------------------------------------------------------
// N-queens backtracking search core
// Depth-first search that returns the next non-attacking placement per item.
// ----------------------------------------------------------------------------
// Usage:
//   Write the board size (1..8) on the cfg channel while the core is idle;
//   the write also clears the search. An s_axis item with tdata[0] = 1
//   restarts the search, with 0 resumes it. One result item per input item
//   leaves on m_axis: tuser = found, tdata = solution number in bits 15:0
//   and the placement (3 bits per column) in bits 39:16.
//   One item at a time: s_axis tready stays low until the result is loaded.
//   A node at column c fetches its row in the loop step, then compares it in
//   the shared attack check with each earlier column in turn; backing out of
//   a column passes through the back step. Each item also passes the start,
//   count and load steps; once the search is exhausted an item goes from the
//   start step straight to the load step. Reset returns the board size to 8
//   and clears the store at once (flip-flops, no clearing pass).
//   A stalled receiver holds the result; the next item can be accepted while
//   it waits and completes once the output register is free.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module n_queens_backtrack_search_core #(
    parameter int MAX_N = nqbs_pkg::DEF_MAX_N
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // config write: board size
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [nqbs_pkg::CFG_W-1:0]         i_cfg_data,
    // tdata: [0] restart, [7:1] zero
    input  logic                               i_s_axis_tvalid,
    output logic                               o_s_axis_tready,
    input  logic [nqbs_pkg::IN_TDATA_W-1:0]    i_s_axis_tdata,
    // tdata: [15:0] solution_number, [39:16] placement
    output logic                               o_m_axis_tvalid,
    input  logic                               i_m_axis_tready,
    output logic [nqbs_pkg::OUT_TDATA_W-1:0]   o_m_axis_tdata,
    // tuser: [0] found
    output logic                               o_m_axis_tuser
);
    import nqbs_pkg::*;

    localparam int NCOL = nq_cols(MAX_N);
    localparam int CW   = $clog2(NCOL + 1);
    localparam int IW   = $clog2(NCOL);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_START = 3'd1;
    localparam logic [2:0] S_LOOP  = 3'd2;
    localparam logic [2:0] S_BACK  = 3'd3;
    localparam logic [2:0] S_CHECK = 3'd4;
    localparam logic [2:0] S_FIN   = 3'd5;
    localparam logic [2:0] S_DONE  = 3'd6;

    logic [2:0]             r_state, n_state;
    logic [CFG_W-1:0]       r_bsize, n_bsize;
    logic [CW-1:0]          r_rows [NCOL];
    logic [CW-1:0]          n_rows [NCOL];
    logic [CW-1:0]          r_col, n_col;
    logic                   r_exh, n_exh;
    logic [SEEN_W-1:0]      r_seen, n_seen;
    logic [CW-1:0]          r_cur, n_cur;
    logic [CW-1:0]          r_i, n_i;
    logic                   r_ovalid, n_ovalid;
    logic                   r_ouser, n_ouser;
    logic [OUT_TDATA_W-1:0] r_odata, n_odata;

    logic                   cfg_acc;
    logic                   in_acc;
    logic [CFG_W-1:0]       n_eff4;
    logic [CW-1:0]          n_eff;
    logic [CW-1:0]          col_c;
    logic [CW-1:0]          col_m1;
    logic                   start_back;
    logic [IW-1:0]          rd_addr;
    logic [CW-1:0]          rd_q;
    logic [CW-1:0]          chk_dist;
    logic                   chk_hit;
    logic [PLACE_W-1:0]     placement;

    assign cfg_acc         = i_cfg_valid && o_cfg_ready;
    assign in_acc          = i_s_axis_tvalid && o_s_axis_tready;
    assign o_cfg_ready     = (r_state == S_IDLE);
    assign o_s_axis_tready = (r_state == S_IDLE) && !i_cfg_valid;

    // Board size in use: zero acts as one, large values saturate
    assign n_eff4 = (r_bsize == '0)           ? CFG_W'(1) :
                    (r_bsize > CFG_W'(NCOL))  ? CFG_W'(NCOL) : r_bsize;
    assign n_eff  = n_eff4[CW-1:0];

    assign col_c      = (r_col > n_eff) ? n_eff : r_col;
    assign col_m1     = col_c - CW'(1);
    assign start_back = (col_c == n_eff) && (col_c != '0);

    // Single addressed read port into the row store for the search steps
    always_comb begin
        rd_addr = '0;
        case (r_state)
            S_START: rd_addr = col_m1[IW-1:0];
            S_LOOP:  rd_addr = r_col[IW-1:0];
            S_BACK:  rd_addr = r_col[IW-1:0];
            S_CHECK: rd_addr = r_i[IW-1:0];
            default: rd_addr = '0;
        endcase
    end

    assign rd_q     = r_rows[rd_addr];
    assign chk_dist = r_col - r_i;

    nqbs_check #(
        .MAX_N      (MAX_N)
    ) u_check (
        .i_row_cur  (r_cur),
        .i_row_prev (rd_q),
        .i_dist     (chk_dist),
        .o_hit      (chk_hit)
    );

    // Columns at or beyond the board size read as zero
    always_comb begin
        placement = '0;
        for (int c = 0; c < NCOL; c++) begin
            if (CW'(c) < n_eff) begin
                placement[c*PLACE_BITS +: PLACE_BITS] = r_rows[c][PLACE_BITS-1:0];
            end
        end
    end

    always_comb begin
        n_state  = r_state;
        n_bsize  = r_bsize;
        n_rows   = r_rows;
        n_col    = r_col;
        n_exh    = r_exh;
        n_seen   = r_seen;
        n_cur    = r_cur;
        n_i      = r_i;
        n_ouser  = r_ouser;
        n_odata  = r_odata;
        n_ovalid = r_ovalid && !i_m_axis_tready;

        case (r_state)
            S_IDLE: begin
                if (cfg_acc || (in_acc && i_s_axis_tdata[0])) begin
                    for (int c = 0; c < NCOL; c++) begin
                        n_rows[c] = '0;
                    end
                    n_col  = '0;
                    n_exh  = 1'b0;
                    n_seen = '0;
                end
                if (cfg_acc) begin
                    n_bsize = i_cfg_data;
                end else if (in_acc) begin
                    n_state = S_START;
                end
            end
            S_START: begin
                if (r_exh) begin
                    n_state = S_DONE;
                end else begin
                    n_state = S_LOOP;
                    // Resume past the last full placement
                    if (start_back) begin
                        n_col           = col_m1;
                        n_rows[rd_addr] = rd_q + CW'(1);
                    end else begin
                        n_col = col_c;
                    end
                end
            end
            S_LOOP: begin
                if (r_col >= n_eff) begin
                    n_state = S_FIN;
                end else if (rd_q >= n_eff) begin
                    n_rows[rd_addr] = '0;
                    if (r_col == '0) begin
                        n_exh   = 1'b1;
                        n_state = S_FIN;
                    end else begin
                        n_col   = r_col - CW'(1);
                        n_state = S_BACK;
                    end
                end else begin
                    n_cur   = rd_q;
                    n_i     = '0;
                    n_state = S_CHECK;
                end
            end
            S_BACK: begin
                // Advance the queen of the column backed into
                n_rows[rd_addr] = rd_q + CW'(1);
                n_state         = S_LOOP;
            end
            S_CHECK: begin
                if (r_i == r_col) begin
                    n_col   = r_col + CW'(1);
                    n_state = S_LOOP;
                end else if (chk_hit) begin
                    n_rows[r_col[IW-1:0]] = r_cur + CW'(1);
                    n_state               = S_LOOP;
                end else begin
                    n_i = r_i + CW'(1);
                end
            end
            S_FIN: begin
                if (!r_exh && (r_seen != SEEN_MAX)) begin
                    n_seen = r_seen + SEEN_W'(1);
                end
                n_state = S_DONE;
            end
            S_DONE: begin
                // Hold until the output register is free
                if (!r_ovalid || i_m_axis_tready) begin
                    n_ovalid = 1'b1;
                    n_ouser  = !r_exh;
                    n_odata  = {(r_exh ? {PLACE_W{1'b0}} : placement), r_seen};
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_bsize  <= BSIZE_RESET;
            for (int c = 0; c < NCOL; c++) begin
                r_rows[c] <= '0;
            end
            r_col    <= '0;
            r_exh    <= 1'b0;
            r_seen   <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_bsize  <= n_bsize;
            r_rows   <= n_rows;
            r_col    <= n_col;
            r_exh    <= n_exh;
            r_seen   <= n_seen;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cur   <= n_cur;
        r_i     <= n_i;
        r_ouser <= n_ouser;
        r_odata <= n_odata;
    end

    assign o_m_axis_tvalid = r_ovalid;
    assign o_m_axis_tdata  = r_odata;
    assign o_m_axis_tuser  = r_ouser;

    `NQ_ASSERT_IMPL(a_col_bound, i_clk, i_rst_n,
        (r_state == S_LOOP) || (r_state == S_CHECK), r_col <= n_eff,
        "column beyond board size")
    `NQ_ASSERT_IMPL(a_scan_bound, i_clk, i_rst_n, r_state == S_CHECK, r_i <= r_col,
        "check index past current column")
    `NQ_ASSERT_IMPL(a_exh_zero, i_clk, i_rst_n, o_m_axis_tvalid && !o_m_axis_tuser,
        o_m_axis_tdata[OUT_TDATA_W-1:SEEN_W] == '0, "exhausted result carries a placement")
    `NQ_ASSERT_IMPL(a_load_done, i_clk, i_rst_n, $rose(o_m_axis_tvalid),
        $past(r_state) == S_DONE, "result loaded outside the done step")

endmodule

// ----- dv/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// N-queens search core testbench
// Drives resume and restart items through the stream ports and changes the
// board size between bursts. Every result item is compared field by field
// with a local backtracking search mirroring the core's state or with fixed
// values for directed items. Both stream sides idle and stall at random.
// ----------------------------------------------------------------------------
module tb;
    import nqbs_pkg::*;

    localparam bit RESUME  = 1'b0;
    localparam bit RESTART = 1'b1;

    localparam int TOTAL_ITEMS = 500;
    localparam int LONG_HOLD   = 3000;
    localparam int HOLD_AT     = 40;
    localparam int CFG_SETTLE  = 8;
    localparam int DRAIN_TAIL  = 30;
    localparam int MAX_REPORTS = 10;

    typedef struct packed {
        bit                  found;
        logic [SEEN_W-1:0]   num;
        logic [PLACE_W-1:0]  place;
    } t_sol;

    // One directed item: optional board size write, then a request item
    typedef struct packed {
        bit                  wr_size;
        logic [CFG_W-1:0]    size;
        bit                  rs;
        bit                  lit;
        t_sol                want;
    } t_step_row;

    logic                     i_clk;
    logic                     i_rst_n;
    logic                     i_cfg_valid;
    logic                     o_cfg_ready;
    logic [CFG_W-1:0]         i_cfg_data;
    logic                     i_s_axis_tvalid;
    logic                     o_s_axis_tready;
    logic [IN_TDATA_W-1:0]    i_s_axis_tdata;
    logic                     o_m_axis_tvalid;
    logic                     i_m_axis_tready;
    logic [OUT_TDATA_W-1:0]   o_m_axis_tdata;
    logic                     o_m_axis_tuser;

    n_queens_backtrack_search_core u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_data      (i_cfg_data),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser)
    );

    // Mirror of the search state
    logic [3:0]        qrow [PLACE_COLS];
    logic [3:0]        cur_col;
    bit                search_over;
    logic [SEEN_W-1:0] nsol;
    logic [CFG_W-1:0]  board_cfg;

    t_sol pending_sol [$];
    int   err_cnt      = 0;
    int   items_sent   = 0;
    int   results_seen = 0;
    bit   tx_quiet     = 0;

    t_step_row steps [25] = '{
        '{1'b0, 4'd0,  RESUME,  1'b1, '{1'b1, 16'd1, 24'h672BE0}},
        '{1'b0, 4'd0,  RESUME,  1'b0, '0},
        '{1'b0, 4'd0,  RESTART, 1'b1, '{1'b1, 16'd1, 24'h672BE0}},
        '{1'b1, 4'd4,  RESUME,  1'b1, '{1'b1, 16'd1, 24'h000419}},
        '{1'b0, 4'd0,  RESUME,  1'b1, '{1'b1, 16'd2, 24'h0002C2}},
        '{1'b0, 4'd0,  RESUME,  1'b1, '{1'b0, 16'd2, 24'h000000}},
        '{1'b0, 4'd0,  RESUME,  1'b1, '{1'b0, 16'd2, 24'h000000}},
        '{1'b0, 4'd0,  RESTART, 1'b1, '{1'b1, 16'd1, 24'h000419}},
        '{1'b1, 4'd1,  RESUME,  1'b1, '{1'b1, 16'd1, 24'h000000}},
        '{1'b0, 4'd0,  RESUME,  1'b1, '{1'b0, 16'd1, 24'h000000}},
        '{1'b1, 4'd0,  RESUME,  1'b1, '{1'b1, 16'd1, 24'h000000}},
        '{1'b1, 4'd2,  RESUME,  1'b1, '{1'b0, 16'd0, 24'h000000}},
        '{1'b0, 4'd0,  RESTART, 1'b1, '{1'b0, 16'd0, 24'h000000}},
        '{1'b1, 4'd3,  RESUME,  1'b1, '{1'b0, 16'd0, 24'h000000}},
        '{1'b1, 4'd15, RESUME,  1'b1, '{1'b1, 16'd1, 24'h672BE0}},
        '{1'b1, 4'd9,  RESUME,  1'b1, '{1'b1, 16'd1, 24'h672BE0}},
        '{1'b0, 4'd0,  RESUME,  1'b0, '0},
        '{1'b1, 4'd5,  RESUME,  1'b0, '0},
        '{1'b0, 4'd0,  RESUME,  1'b0, '0},
        '{1'b0, 4'd0,  RESUME,  1'b0, '0},
        '{1'b0, 4'd0,  RESUME,  1'b0, '0},
        '{1'b0, 4'd0,  RESTART, 1'b0, '0},
        '{1'b1, 4'd6,  RESUME,  1'b0, '0},
        '{1'b1, 4'd7,  RESUME,  1'b0, '0},
        '{1'b0, 4'd0,  RESUME,  1'b0, '0}
    };

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        #80_000_000;
        $display("tb: failure");
        $finish;
    end

    function automatic void clear_search();
        foreach (qrow[k]) qrow[k] = '0;
        cur_col     = '0;
        search_over = 1'b0;
        nsol        = '0;
    endfunction

    function automatic bit no_attack(input int c);
        int q;
        int r;
        int d;
        r = qrow[c];
        for (int i = 0; i < c; i++) begin
            q = qrow[i];
            d = c - i;
            if (q == r || r - q == d || q - r == d)
                return 1'b0;
        end
        return 1'b1;
    endfunction

    // Resume the depth-first search, or restart it when rs is set, up to the next full placement
    function automatic t_sol search_next(input bit rs);
        t_sol res;
        int   n;
        int   c;
        n = (board_cfg == 0) ? 1 : ((board_cfg > PLACE_COLS) ? PLACE_COLS : board_cfg);
        if (rs)
            clear_search();
        if (!search_over) begin
            c = (cur_col > n) ? n : cur_col;
            // step off the last placement found
            if (c == n && c > 0) begin
                c--;
                qrow[c]++;
            end
            while (c < n) begin
                if (qrow[c] >= n) begin
                    qrow[c] = '0;
                    if (c == 0) begin
                        search_over = 1'b1;
                        break;
                    end
                    c--;
                    qrow[c]++;
                end else if (no_attack(c)) begin
                    c++;
                end else begin
                    qrow[c]++;
                end
            end
            cur_col = c[3:0];
            if (!search_over && nsol != SEEN_MAX)
                nsol++;
        end
        res       = '0;
        res.num   = nsol;
        res.found = !search_over;
        if (!search_over)
            for (int i = 0; i < n; i++)
                res.place[PLACE_BITS*i +: PLACE_BITS] = qrow[i][PLACE_BITS-1:0];
        return res;
    endfunction

    function automatic int pick_gap();
        return ($urandom_range(0, 9) == 0) ? $urandom_range(20, 80) : $urandom_range(1, 3);
    endfunction

    task automatic hold_until_drained();
        i_s_axis_tvalid <= 1'b0;
        while (pending_sol.size() != 0)
            @(posedge i_clk);
    endtask

    task automatic write_board(input logic [CFG_W-1:0] v);
        hold_until_drained();
        repeat (CFG_SETTLE) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= v;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        board_cfg = v;
        clear_search();
    endtask

    task automatic send_item(input bit rs, input bit lit, input t_sol want);
        t_sol exp_sol;
        int   gap;
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= {{(IN_TDATA_W-1){1'b0}}, rs};
        do @(posedge i_clk); while (!o_s_axis_tready);
        exp_sol = search_next(rs);
        pending_sol.push_back(lit ? want : exp_sol);
        items_sent++;
        gap = tx_quiet ? 0 : ($urandom_range(0, 1) ? 0 : pick_gap());
        if (gap > 0) begin
            i_s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // Result side: check each accepted item, stall at random
    initial begin
        t_sol want;
        t_sol got;
        int   hold_left;
        bit   long_done;
        bit   rx_quiet;
        hold_left = 0;
        long_done = 0;
        i_m_axis_tready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (o_m_axis_tvalid === 1'b1 && i_m_axis_tready) begin
                got.found = o_m_axis_tuser;
                got.num   = o_m_axis_tdata[SEEN_W-1:0];
                got.place = o_m_axis_tdata[SEEN_W +: PLACE_W];
                results_seen++;
                if (pending_sol.size() == 0) begin
                    err_cnt++;
                    if (err_cnt <= MAX_REPORTS)
                        $display("tb: unexpected result found=%0d num=%0d place=%06h",
                                 got.found, got.num, got.place);
                end else begin
                    want = pending_sol.pop_front();
                    if (got !== want) begin
                        err_cnt++;
                        if (err_cnt <= MAX_REPORTS)
                            $display("tb: result %0d exp %0d/%0d/%06h got %0d/%0d/%06h",
                                     results_seen, want.found, want.num, want.place,
                                     got.found, got.num, got.place);
                    end
                end
            end
            rx_quiet = ((results_seen / 50) % 4) == 2;
            if (!long_done && results_seen == HOLD_AT) begin
                // starve the output so the core backs up into its input
                long_done = 1;
                hold_left = LONG_HOLD - 1;
                i_m_axis_tready <= 1'b0;
            end else if (hold_left > 0) begin
                hold_left--;
                i_m_axis_tready <= 1'b0;
            end else if (!rx_quiet && $urandom_range(0, 7) == 0) begin
                hold_left = pick_gap() - 1;
                i_m_axis_tready <= 1'b0;
            end else begin
                i_m_axis_tready <= 1'b1;
            end
        end
    end

    initial begin
        int          phase;
        int          burst;
        int          pick;
        logic [CFG_W-1:0] sz;
        i_rst_n         <= 1'b0;
        i_cfg_valid     <= 1'b0;
        i_cfg_data      <= '0;
        i_s_axis_tvalid <= 1'b0;
        i_s_axis_tdata  <= '0;
        board_cfg = BSIZE_RESET;
        clear_search();
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (steps[k]) begin
            if (steps[k].wr_size)
                write_board(steps[k].size);
            send_item(steps[k].rs, steps[k].lit, steps[k].want);
        end

        // Walk the full eight-by-eight search past exhaustion
        write_board(4'd8);
        for (int k = 0; k < 95; k++)
            send_item(RESUME, 1'b0, '0);

        phase = 0;
        while (items_sent < TOTAL_ITEMS) begin
            pick = $urandom_range(0, 19);
            if (pick < 12)
                sz = CFG_W'($urandom_range(1, 6));
            else if (pick < 16)
                sz = 4'd7;
            else if (pick < 18)
                sz = 4'd8;
            else if (pick == 18)
                sz = 4'd0;
            else
                sz = CFG_W'($urandom_range(9, 15));
            write_board(sz);
            burst    = (sz == 0 || sz > 7) ? $urandom_range(1, 20) : $urandom_range(1, 48);
            tx_quiet = ($urandom_range(0, 3) == 0);
            for (int k = 0; k < burst; k++) begin
                if (phase == 2 && k == burst / 2)
                    hold_until_drained();
                send_item(($urandom_range(0, 11) == 0) ? RESTART : RESUME, 1'b0, '0);
            end
            phase++;
        end

        hold_until_drained();
        repeat (DRAIN_TAIL) @(posedge i_clk);
        err_cnt += pending_sol.size();
        if (err_cnt == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
